### hdl/knps_pkg.sv
// shared constants, candidate record and cell control for the nearest point selector
// no dependencies; compiled first
package knps_pkg;

  localparam int MAX_POINTS   = 64;
  localparam int MAX_PICKS    = 6;
  localparam int COORD_W      = 28;
  localparam int PICK_W       = 3;
  localparam int IDX_W        = $clog2(MAX_POINTS);
  localparam int CNT_W        = $clog2(MAX_POINTS + 1);
  localparam int SQ_W         = 2 * COORD_W;
  localparam int DIST_W       = SQ_W + 2;
  localparam int PIPE_DEPTH   = 3;
  localparam int DRAIN_CYCLES = PIPE_DEPTH + MAX_PICKS + 1;
  localparam int DRAIN_W      = $clog2(DRAIN_CYCLES + 1);
  localparam int EMIT_W       = $clog2(MAX_PICKS + 1);
  localparam int CFG_IDX_W    = 2;

  localparam logic [PICK_W-1:0] PICK_COUNT_RST = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PICK_COUNT = 2'd0,
    CFG_CENTRE_X   = 2'd1,
    CFG_CENTRE_Y   = 2'd2,
    CFG_CENTRE_Z   = 2'd3
  } cfg_reg_e;

  // one candidate point travelling through the distance pipe and the cell row
  typedef struct packed {
    logic               vld;
    logic [DIST_W-1:0]  dist_sq;
    logic [IDX_W-1:0]   idx;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } cand_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage

### hdl/knps_dist.sv
// three-stage squared distance pipe: axis difference, square, sum
// depends on knps_pkg
module knps_dist (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          vld_i,
  input  logic [knps_pkg::IDX_W-1:0]    idx_i,
  input  logic [knps_pkg::COORD_W-1:0]  px_i,
  input  logic [knps_pkg::COORD_W-1:0]  py_i,
  input  logic [knps_pkg::COORD_W-1:0]  pz_i,
  input  logic [knps_pkg::COORD_W-1:0]  cx_i,
  input  logic [knps_pkg::COORD_W-1:0]  cy_i,
  input  logic [knps_pkg::COORD_W-1:0]  cz_i,
  output knps_pkg::cand_t               cand_o
);
  import knps_pkg::*;

  // magnitude of a signed difference; it always fits the coordinate width
  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] p,
                                                   input logic [COORD_W-1:0] c);
    logic [COORD_W:0] d;
    logic [COORD_W:0] n;
    d = {p[COORD_W-1], p} - {c[COORD_W-1], c};
    n = -d;
    return d[COORD_W] ? n[COORD_W-1:0] : d[COORD_W-1:0];
  endfunction

  logic               s1_vld_q, s2_vld_q, s3_vld_q;
  logic [IDX_W-1:0]   s1_idx_q, s2_idx_q;
  logic [COORD_W-1:0] s1_x_q, s1_y_q, s1_z_q;
  logic [COORD_W-1:0] s2_x_q, s2_y_q, s2_z_q;
  logic [COORD_W-1:0] s1_ax_q, s1_ay_q, s1_az_q;
  logic [SQ_W-1:0]    s2_sx_q, s2_sy_q, s2_sz_q;
  cand_t              s3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= idx_i;
    s1_x_q   <= px_i;
    s1_y_q   <= py_i;
    s1_z_q   <= pz_i;
    s1_ax_q  <= abs_diff(px_i, cx_i);
    s1_ay_q  <= abs_diff(py_i, cy_i);
    s1_az_q  <= abs_diff(pz_i, cz_i);

    s2_idx_q <= s1_idx_q;
    s2_x_q   <= s1_x_q;
    s2_y_q   <= s1_y_q;
    s2_z_q   <= s1_z_q;
    s2_sx_q  <= SQ_W'(s1_ax_q) * SQ_W'(s1_ax_q);
    s2_sy_q  <= SQ_W'(s1_ay_q) * SQ_W'(s1_ay_q);
    s2_sz_q  <= SQ_W'(s1_az_q) * SQ_W'(s1_az_q);

    s3_q.vld     <= 1'b0;
    s3_q.dist_sq <= DIST_W'(s2_sx_q) + DIST_W'(s2_sy_q) + DIST_W'(s2_sz_q);
    s3_q.idx     <= s2_idx_q;
    s3_q.x       <= s2_x_q;
    s3_q.y       <= s2_y_q;
    s3_q.z       <= s2_z_q;
  end

  always_comb begin
    cand_o     = s3_q;
    cand_o.vld = s3_vld_q;
  end

endmodule

### hdl/knps_cell.sv
// one sorted row cell: keeps the lesser of (stored, incoming) and passes the other on;
// on shift it loads the next cell's point, on clear it empties; depends on knps_pkg
module knps_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  knps_pkg::cell_ctrl_t ctrl_i,
  input  knps_pkg::cand_t      cand_i,
  input  knps_pkg::cand_t      next_i,
  output knps_pkg::cand_t      stored_o,
  output knps_pkg::cand_t      pass_o
);
  import knps_pkg::*;

  cand_t st_q, st_d;
  cand_t pass_q, pass_d;
  logic  in_less;

  // order by distance, then by list position
  assign in_less = (cand_i.dist_sq < st_q.dist_sq) ||
                   ((cand_i.dist_sq == st_q.dist_sq) && (cand_i.idx < st_q.idx));

  always_comb begin
    st_d   = st_q;
    pass_d = cand_i;
    if (ctrl_i.clear) begin
      st_d.vld   = 1'b0;
      pass_d.vld = 1'b0;
    end else if (ctrl_i.shift) begin
      st_d       = next_i;
      pass_d.vld = 1'b0;
    end else if (cand_i.vld && (!st_q.vld || in_less)) begin
      st_d   = cand_i;
      pass_d = st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= '0;
      pass_q <= '0;
    end else begin
      st_q   <= st_d;
      pass_q <= pass_d;
    end
  end

  assign stored_o = st_q;
  assign pass_o   = pass_q;

endmodule

### hdl/k_nearest_point_select_top.sv
// top level of the nearest point selector: load control, cell row, result register
// depends on knps_pkg, knps_dist, knps_cell
//
// usage
//   input channel (in_valid_i / in_stall_o): one point per beat, with exclude and
//   last flags. points load at one beat per cycle while in_stall_o is low; each is
//   turned into a squared distance by a 3-stage pipe and pushed into a row of
//   MAX_PICKS cells that keeps the nearest points sorted by (distance, list
//   position). points past MAX_POINTS and excluded points never enter the row.
//   after the beat marked last, in_stall_o stays high: the row settles while the
//   last point clears the distance pipe, then results leave at one beat per cycle
//   while out_stall_i is low, nearest first, by shifting the row toward the head.
//   a run with no pick gives one beat with found_o low. last_result_o marks the
//   final beat of a run. the wait from the last point to the first result is set
//   by the drain of the distance pipe and the cell row.
//   output channel (out_valid_o / out_stall_i): a result sits in a register and
//   holds while stalled; the row shifts only when that register frees up.
//   the next list is taken once the final result beat has been taken.
//   config port (cfg_valid_i / cfg_ready_o): always ready; index 0 pick_count,
//   1..3 centre x/y/z. write only while idle.
//   reset: row empty, list empty, pick_count 4, centre at the origin.
module k_nearest_point_select_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,

  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [knps_pkg::COORD_W-1:0]  point_x_i,
  input  logic signed [knps_pkg::COORD_W-1:0]  point_y_i,
  input  logic signed [knps_pkg::COORD_W-1:0]  point_z_i,
  input  logic                                 exclude_point_i,
  input  logic                                 last_point_i,

  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 found_o,
  output logic [knps_pkg::IDX_W-1:0]           point_index_o,
  output logic signed [knps_pkg::COORD_W-1:0]  sel_x_o,
  output logic signed [knps_pkg::COORD_W-1:0]  sel_y_o,
  output logic signed [knps_pkg::COORD_W-1:0]  sel_z_o,
  output logic                                 last_result_o,

  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [knps_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [knps_pkg::COORD_W-1:0]         cfg_data_i
);
  import knps_pkg::*;

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_DRAIN = 4'b0010,
    ST_EMIT  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [PICK_W-1:0]  pick_count_q;
  logic [COORD_W-1:0] centre_x_q, centre_y_q, centre_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pick_count_q <= PICK_COUNT_RST;
      centre_x_q   <= '0;
      centre_y_q   <= '0;
      centre_z_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_PICK_COUNT: pick_count_q <= cfg_data_i[PICK_W-1:0];
        CFG_CENTRE_X:   centre_x_q   <= cfg_data_i;
        CFG_CENTRE_Y:   centre_y_q   <= cfg_data_i;
        CFG_CENTRE_Z:   centre_z_q   <= cfg_data_i;
        default:        pick_count_q <= pick_count_q;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // input side: list position counter, saturating at the list size
  logic             in_acc;
  logic             ins_vld;
  logic [CNT_W-1:0] count_q, count_d;

  assign in_stall_o = (state_q != ST_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ins_vld    = in_acc && !exclude_point_i && (count_q < CNT_W'(MAX_POINTS));

  cand_t dist_cand;

  knps_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (ins_vld),
    .idx_i  (count_q[IDX_W-1:0]),
    .px_i   (point_x_i),
    .py_i   (point_y_i),
    .pz_i   (point_z_i),
    .cx_i   (centre_x_q),
    .cy_i   (centre_y_q),
    .cz_i   (centre_z_q),
    .cand_o (dist_cand)
  );

  // row of cells, head at index 0 holds the nearest point
  cell_ctrl_t ctrl;
  cand_t      cell_in [MAX_PICKS];
  cand_t      stored  [MAX_PICKS];
  cand_t      pass    [MAX_PICKS];
  cand_t      nxt     [MAX_PICKS];

  for (genvar i = 0; i < MAX_PICKS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_in[i] = dist_cand;
    end else begin : g_body
      assign cell_in[i] = pass[i-1];
    end
    if (i == MAX_PICKS - 1) begin : g_tail
      assign nxt[i] = '0;
    end else begin : g_link
      assign nxt[i] = stored[i+1];
    end

    knps_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .cand_i   (cell_in[i]),
      .next_i   (nxt[i]),
      .stored_o (stored[i]),
      .pass_o   (pass[i])
    );
  end

  // selection control
  logic [DRAIN_W-1:0] drain_q, drain_d;
  logic [EMIT_W-1:0]  emit_cnt_q, emit_cnt_d;
  logic [EMIT_W-1:0]  pick_lim;
  logic               out_free;
  logic               out_acc;

  // result register
  logic               out_vld_q, out_vld_d;
  logic               out_found_q, out_found_d;
  logic [IDX_W-1:0]   out_idx_q, out_idx_d;
  logic [COORD_W-1:0] out_x_q, out_x_d, out_y_q, out_y_d, out_z_q, out_z_d;
  logic               out_last_q, out_last_d;

  assign pick_lim = (int'(pick_count_q) > MAX_PICKS) ? EMIT_W'(MAX_PICKS)
                                                     : EMIT_W'(pick_count_q);
  assign out_acc  = out_vld_q && !out_stall_i;
  assign out_free = !out_vld_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    drain_d     = drain_q;
    emit_cnt_d  = emit_cnt_q;
    ctrl        = '0;
    out_vld_d   = out_vld_q && !out_acc;
    out_found_d = out_found_q;
    out_idx_d   = out_idx_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_z_d     = out_z_q;
    out_last_d  = out_last_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (count_q < CNT_W'(MAX_POINTS)) begin
            count_d = count_q + CNT_W'(1);
          end
          if (last_point_i) begin
            state_d = ST_DRAIN;
            drain_d = DRAIN_W'(DRAIN_CYCLES);
          end
        end
      end
      ST_DRAIN: begin
        // let the last point clear the distance pipe and settle in the row
        drain_d = drain_q - DRAIN_W'(1);
        if (drain_q == DRAIN_W'(1)) begin
          state_d    = ST_EMIT;
          emit_cnt_d = '0;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          if ((emit_cnt_q == '0) && ((pick_lim == '0) || !stored[0].vld)) begin
            // nothing qualifies: a single empty result closes the run
            out_found_d = 1'b0;
            out_idx_d   = '0;
            out_x_d     = '0;
            out_y_d     = '0;
            out_z_d     = '0;
            out_last_d  = 1'b1;
            state_d     = ST_FLUSH;
          end else begin
            out_found_d = 1'b1;
            out_idx_d   = stored[0].idx;
            out_x_d     = stored[0].x;
            out_y_d     = stored[0].y;
            out_z_d     = stored[0].z;
            out_last_d  = ((emit_cnt_q + EMIT_W'(1)) == pick_lim) || !nxt[0].vld;
            ctrl.shift  = 1'b1;
            emit_cnt_d  = emit_cnt_q + EMIT_W'(1);
            if (out_last_d) begin
              state_d = ST_FLUSH;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (out_acc) begin
          ctrl.clear = 1'b1;
          count_d    = '0;
          state_d    = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      count_q    <= '0;
      drain_q    <= '0;
      emit_cnt_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      drain_q    <= drain_d;
      emit_cnt_q <= emit_cnt_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_found_q <= out_found_d;
    out_idx_q   <= out_idx_d;
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
    out_z_q     <= out_z_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o   = out_vld_q;
  assign found_o       = out_found_q;
  assign point_index_o = out_idx_q;
  assign sel_x_o       = out_x_q;
  assign sel_y_o       = out_y_q;
  assign sel_z_o       = out_z_q;
  assign last_result_o = out_last_q;

  // an empty result always closes its run
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_found_q |-> out_last_q)
    else $error("empty result without last flag");

  // never more results than picks
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> (emit_cnt_q == '0) || (emit_cnt_q < pick_lim))
    else $error("result count past pick limit");

  // a list end always starts the drain
  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_point_i |=> state_q == ST_DRAIN)
    else $error("last point did not start selection");

  // no result left pending while loading
  a_load_idle_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOAD |-> !out_vld_q)
    else $error("result pending during load");

endmodule
